// File: hdl/khp_pkg.sv
// Shared types and codes for the keyed min-heap top-k unit.
// No dependencies.
package khp_pkg;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_ADD     = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SU_REQ,
    S_SU_CMP,
    S_SD_REQL,
    S_SD_REQR,
    S_SD_CMP,
    S_EX_REQ,
    S_EX_LAT,
    S_ROOT_REQ,
    S_ROOT_LAT,
    S_DONE
  } fsm_t;

  localparam int unsigned KEY_PORT_BITS   = 64;
  localparam int unsigned VALUE_PORT_BITS = 32;
  localparam int unsigned COUNT_PORT_BITS = 8;

endpackage

// File: hdl/khp_ram.sv
// Single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module khp_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/keyed_min_heap_top_k_unit.sv
// Keyed min-heap top-k unit: heap sequencer around one entry RAM.
// Depends on khp_pkg and khp_ram.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request: operation, flow_id,
//   amount. Output channel (out_valid/out_stall) returns one result per request:
//   status, root key and value after the operation, and entry count.
//   A request is taken only when the sequencer is idle; one request is worked
//   at a time. The result register lets the next request be taken while the
//   previous result is still stalled at the output.
//   Work per request: set/add scans the held entries for the key through
//   the RAM read port, one entry per cycle, then sifts up, and down as well
//   when the key was found, then reads the root. Extract reads the last entry
//   into the root and sifts it down, then reads the root. The key scan on the
//   single read port dominates the time of an update on a large heap.
//   Reset clears the entry count and the handshake state; RAM contents are
//   not cleared, since only positions below the count are ever used.
//   A stalled result holds in the output register; the sequencer waits in
//   its final state until the register is free.
module keyed_min_heap_top_k_unit #(
  parameter int unsigned HEAP_SLOTS = 256,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_operation,
  input  logic [khp_pkg::KEY_PORT_BITS-1:0]   in_flow_id,
  input  logic [khp_pkg::VALUE_PORT_BITS-1:0] in_amount,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [khp_pkg::KEY_PORT_BITS-1:0]   out_min_key,
  output logic [khp_pkg::VALUE_PORT_BITS-1:0] out_min_value,
  output logic [khp_pkg::COUNT_PORT_BITS-1:0] out_entry_count
);
  import khp_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_SLOTS);
  localparam int unsigned CW = AW + 2;
  localparam int unsigned EW = KEY_BITS + VALUE_BITS;
  localparam logic [AW-1:0] LAST_FREE = AW'(HEAP_SLOTS - 1);

  fsm_t state_r, state_nxt;

  logic [AW-1:0]         count_r, count_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] amt_r, amt_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [KEY_BITS-1:0]   cur_key_r, cur_key_nxt;
  logic [VALUE_BITS-1:0] cur_val_r, cur_val_nxt;
  logic                  down_r, down_nxt;
  logic [AW-1:0]         scan_r, scan_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic [AW-1:0]         chk_idx_r, chk_idx_nxt;
  logic [EW-1:0]         lent_r, lent_nxt;
  status_t               status_r, status_nxt;
  logic [KEY_BITS-1:0]   res_key_r, res_key_nxt;
  logic [VALUE_BITS-1:0] res_val_r, res_val_nxt;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [KEY_PORT_BITS-1:0]   out_key_r;
  logic [VALUE_PORT_BITS-1:0] out_val_r;
  logic [COUNT_PORT_BITS-1:0] out_cnt_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  logic [KEY_BITS-1:0]   rd_key, lent_key;
  logic [VALUE_BITS-1:0] rd_val, lent_val, best_val;
  logic [AW-1:0]         parent;
  logic [CW-1:0]         lchild, rchild, count_w;
  logic                  accept, scan_hit, scan_miss, l_ok, r_ok, sel_l, sel_r, out_free;

  khp_ram #(.WIDTH(EW), .DEPTH(HEAP_SLOTS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_key   = mem_rdata[EW-1:VALUE_BITS];
  assign rd_val   = mem_rdata[VALUE_BITS-1:0];
  assign lent_key = lent_r[EW-1:VALUE_BITS];
  assign lent_val = lent_r[VALUE_BITS-1:0];
  assign parent   = (idx_r - 1'b1) >> 1;
  assign count_w  = CW'(count_r);
  assign lchild   = {1'b0, idx_r, 1'b1};
  assign rchild   = {1'b0, idx_r, 1'b0} + CW'(2);
  assign l_ok     = lchild < count_w;
  assign r_ok     = rchild < count_w;
  assign sel_l    = lent_val < cur_val_r;
  assign best_val = sel_l ? lent_val : cur_val_r;
  assign sel_r    = r_ok && (rd_val < best_val);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign scan_hit = chk_v_r && (rd_key == key_r);
  // scan ends when the last held slot was checked, or nothing was held
  assign scan_miss = !scan_hit && ((chk_v_r && chk_idx_r == count_r - 1'b1) ||
                                   (!chk_v_r && scan_r == count_r));

  assign in_stall = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_SET, OP_ADD: state_nxt = S_SCAN;
            OP_EXTRACT:     state_nxt = (count_r == '0) ? S_ROOT_REQ : S_EX_REQ;
            default:        state_nxt = S_ROOT_REQ;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = S_SU_REQ;
        end else if (scan_miss) begin
          state_nxt = (count_r == LAST_FREE) ? S_ROOT_REQ : S_SU_REQ;
        end
      end
      S_SU_REQ: begin
        if (idx_r == '0) begin
          state_nxt = down_r ? S_SD_REQL : S_ROOT_REQ;
        end else begin
          state_nxt = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        if (cur_val_r < rd_val) begin
          state_nxt = S_SU_REQ;
        end else begin
          state_nxt = down_r ? S_SD_REQL : S_ROOT_REQ;
        end
      end
      S_SD_REQL:  state_nxt = l_ok ? S_SD_REQR : S_ROOT_REQ;
      S_SD_REQR:  state_nxt = S_SD_CMP;
      S_SD_CMP:   state_nxt = (sel_r || sel_l) ? S_SD_REQL : S_ROOT_REQ;
      S_EX_REQ:   state_nxt = S_EX_LAT;
      S_EX_LAT:   state_nxt = (count_r == AW'(1)) ? S_ROOT_REQ : S_SD_REQL;
      S_ROOT_REQ: state_nxt = (count_r == '0) ? S_DONE : S_ROOT_LAT;
      S_ROOT_LAT: state_nxt = S_DONE;
      S_DONE:     state_nxt = out_free ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    count_nxt   = count_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    amt_nxt     = amt_r;
    idx_nxt     = idx_r;
    cur_key_nxt = cur_key_r;
    cur_val_nxt = cur_val_r;
    down_nxt    = down_r;
    scan_nxt    = scan_r;
    chk_v_nxt   = 1'b0;
    chk_idx_nxt = chk_idx_r;
    lent_nxt    = lent_r;
    status_nxt  = status_r;
    res_key_nxt = res_key_r;
    res_val_nxt = res_val_r;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_wdata   = {cur_key_r, cur_val_r};
    mem_raddr   = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_operation;
          key_nxt    = KEY_BITS'(in_flow_id);
          amt_nxt    = VALUE_BITS'(in_amount);
          scan_nxt   = '0;
          status_nxt = (in_operation == OP_EXTRACT && count_r == '0) ? ST_EMPTY : ST_OK;
        end
      end
      S_SCAN: begin
        cur_key_nxt = key_r;
        if (scan_hit) begin
          idx_nxt     = chk_idx_r;
          cur_val_nxt = (op_r == OP_ADD) ? rd_val + amt_r : amt_r;
          down_nxt    = 1'b1;
        end else if (scan_miss) begin
          if (count_r == LAST_FREE) begin
            status_nxt = ST_FULL;
          end else begin
            idx_nxt     = count_r;
            cur_val_nxt = amt_r;
            count_nxt   = count_r + 1'b1;
            down_nxt    = 1'b0;
          end
        end else if (scan_r < count_r) begin
          mem_raddr   = scan_r;
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = scan_r;
          scan_nxt    = scan_r + 1'b1;
        end
      end
      S_SU_REQ: begin
        mem_raddr = parent;
        if (idx_r == '0 && !down_r) begin
          mem_we = 1'b1;
        end
      end
      S_SU_CMP: begin
        if (cur_val_r < rd_val) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          idx_nxt   = parent;
        end else if (!down_r) begin
          mem_we = 1'b1;
        end
      end
      S_SD_REQL: begin
        mem_raddr = AW'(lchild);
        if (!l_ok) begin
          mem_we = 1'b1;
        end
      end
      S_SD_REQR: begin
        lent_nxt  = mem_rdata;
        mem_raddr = AW'(rchild);
      end
      S_SD_CMP: begin
        mem_we = 1'b1;
        if (sel_r) begin
          mem_wdata = mem_rdata;
          idx_nxt   = AW'(rchild);
        end else if (sel_l) begin
          mem_wdata = {lent_key, lent_val};
          idx_nxt   = AW'(lchild);
        end
      end
      S_EX_REQ: begin
        mem_raddr = count_r - 1'b1;
      end
      S_EX_LAT: begin
        cur_key_nxt = rd_key;
        cur_val_nxt = rd_val;
        idx_nxt     = '0;
        down_nxt    = 1'b1;
        count_nxt   = count_r - 1'b1;
      end
      S_ROOT_REQ: begin
        mem_raddr   = '0;
        res_key_nxt = '0;
        res_val_nxt = '0;
      end
      S_ROOT_LAT: begin
        res_key_nxt = rd_key;
        res_val_nxt = rd_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      chk_v_r <= chk_v_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    amt_r     <= amt_nxt;
    idx_r     <= idx_nxt;
    cur_key_r <= cur_key_nxt;
    cur_val_r <= cur_val_nxt;
    down_r    <= down_nxt;
    scan_r    <= scan_nxt;
    chk_idx_r <= chk_idx_nxt;
    lent_r    <= lent_nxt;
    status_r  <= status_nxt;
    res_key_r <= res_key_nxt;
    res_val_r <= res_val_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r <= status_r;
      out_key_r    <= KEY_PORT_BITS'(res_key_r);
      out_val_r    <= VALUE_PORT_BITS'(res_val_r);
      out_cnt_r    <= COUNT_PORT_BITS'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_min_key     = out_key_r;
  assign out_min_value   = out_val_r;
  assign out_entry_count = out_cnt_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_FREE)
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ((count_r == $past(count_r) + 1'b1) || (count_r == $past(count_r) - 1'b1)))
    else $error("entry count moved by more than one");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside final state");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE && state_r != S_DONE))
    else $error("RAM written while no request in work");
`endif

endmodule
